FILE: rtl/msam_pkg.sv
// package for the multi-stream averaging mixer
// shared constants, function codes and the controller/datapath interface types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package msam_pkg;

    localparam int DEF_BUFFER_DEPTH = 64;
    localparam int DEF_MAX_STREAMS  = 8;
    localparam int DEF_SAMPLE_BITS  = 16;

    localparam int FUNC_W      = 2;
    localparam int IDX_W       = 3;
    localparam int CFG_W       = 4;
    localparam int MASK_W      = 8;
    localparam int DONE_W      = 4;
    localparam int MIN_STREAMS = 2;

    localparam logic [CFG_W-1:0]  CFG_RESET = 4'd2;
    localparam logic [DONE_W-1:0] DONE_MAX  = 4'd15;

    localparam logic [FUNC_W-1:0] FUNC_MIX  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_END  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CONV = 2'd2;

    typedef struct packed {
        logic load;
        logic mix_read;
        logic mix_write;
        logic end_apply;
        logic scan_start;
        logic scan_step;
        logic conv_read;
        logic div_start;
        logic emit;
        logic emit_none;
        logic conv_finish;
    } cmd_t;

    typedef struct packed {
        logic is_mix;
        logic is_end;
        logic is_conv;
        logic inactive;
        logic scan_last;
        logic avail_zero;
        logic div_done;
        logic out_free;
        logic run_last;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/msam_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module msam_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/msam_ctrl.sv
// controller state machine of the mixer
// depends on msam_pkg for the command and status types
`timescale 1ns / 1ps
`default_nettype none

module msam_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire msam_pkg::sts_t sts,
    output msam_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MIX_WR,
        ST_SCAN,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT,
        ST_EMIT_NONE,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (sts.is_mix && !sts.inactive)
                begin
                    cmd.mix_read = 1'b1;
                    state_next   = ST_MIX_WR;
                end
                else if (sts.is_end && !sts.inactive)
                begin
                    cmd.end_apply = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (sts.is_conv)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MIX_WR:
            begin
                cmd.mix_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.avail_zero)
                begin
                    state_next = ST_EMIT_NONE;
                end
                else
                begin
                    cmd.conv_read = 1'b1;
                    state_next    = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.run_last ? ST_FINISH : ST_CHECK;
                end
            end
            ST_EMIT_NONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                cmd.conv_finish = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        stall_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign item_stall = stall_reg;

endmodule

`default_nettype wire

FILE: rtl/msam_datapath.sv
// datapath of the mixer: offsets, accumulator ram, divider and output register
// depends on msam_pkg and msam_ram
`timescale 1ns / 1ps
`default_nettype none

module msam_datapath #(
    parameter int BUFFER_DEPTH = msam_pkg::DEF_BUFFER_DEPTH,
    parameter int MAX_STREAMS  = msam_pkg::DEF_MAX_STREAMS,
    parameter int SAMPLE_BITS  = msam_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [msam_pkg::FUNC_W-1:0]       func,
    input  wire logic [msam_pkg::IDX_W-1:0]        stream_index,
    input  wire logic signed [SAMPLE_BITS-1:0]     sample_left,
    input  wire logic signed [SAMPLE_BITS-1:0]     sample_right,
    input  wire logic                              last_of_chunk,
    input  wire logic                              active_streams_we,
    input  wire logic [msam_pkg::CFG_W-1:0]        active_streams,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output logic signed [SAMPLE_BITS-1:0]          mixed_left,
    output logic signed [SAMPLE_BITS-1:0]          mixed_right,
    output logic                                   sample_valid,
    output logic                                   last_of_run,
    output logic [msam_pkg::MASK_W-1:0]            need_mask,
    input  wire msam_pkg::cmd_t                    cmd,
    output msam_pkg::sts_t                         sts
);

    localparam int ACC_W = SAMPLE_BITS + 3;
    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int OW    = $clog2(BUFFER_DEPTH + 1);
    localparam int SW    = $clog2(MAX_STREAMS);
    localparam int NW    = $clog2(MAX_STREAMS + 1);
    localparam int CW    = $clog2(ACC_W + 1);
    localparam int DW    = msam_pkg::DONE_W;

    localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W + 1)'((64'd1 << (ACC_W - 1)) - 64'd1);
    localparam logic signed [ACC_W:0] ACC_MIN = -ACC_MAX - (ACC_W + 1)'(1);
    localparam logic signed [ACC_W:0] OUT_MAX =
        (ACC_W + 1)'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [ACC_W:0] OUT_MIN = -OUT_MAX - (ACC_W + 1)'(1);

    // held transaction
    logic [msam_pkg::FUNC_W-1:0]   func_reg;
    logic [msam_pkg::IDX_W-1:0]    idx_reg;
    logic signed [SAMPLE_BITS-1:0] sl_reg;
    logic signed [SAMPLE_BITS-1:0] sr_reg;
    logic                          last_reg;

    logic [msam_pkg::CFG_W-1:0]    active_reg;
    logic [OW-1:0]                 offset_reg [MAX_STREAMS];
    logic [OW-1:0]                 fill_reg;
    logic [AW-1:0]                 rp_reg;
    logic [DW-1:0]                 done_reg;
    logic [BUFFER_DEPTH-1:0]       valid_reg;
    logic [OW-1:0]                 min_reg;
    logic [SW-1:0]                 scan_idx_reg;
    logic [OW-1:0]                 k_reg;
    logic [AW-1:0]                 addr_reg;
    logic                          vld_rd_reg;

    // divider
    logic [CW-1:0]                 cnt_reg;
    logic [ACC_W-1:0]              num_l_reg;
    logic [ACC_W-1:0]              num_r_reg;
    logic [DW-1:0]                 rem_l_reg;
    logic [DW-1:0]                 rem_r_reg;
    logic                          neg_l_reg;
    logic                          neg_r_reg;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_l_reg;
    logic signed [SAMPLE_BITS-1:0] out_r_reg;
    logic                          out_sv_reg;
    logic                          out_last_reg;
    logic [msam_pkg::MASK_W-1:0]   out_mask_reg;

    logic [NW-1:0]                 n_streams;
    logic [SW-1:0]                 sel;
    logic [OW-1:0]                 off_rd;
    logic                          off_ok;
    logic [AW-1:0]                 mix_addr;
    logic [AW-1:0]                 conv_addr;
    logic [AW-1:0]                 raddr;
    logic [2*ACC_W-1:0]            ram_rdata;
    logic [2*ACC_W-1:0]            ram_wdata;
    logic                          ram_we;
    logic signed [ACC_W-1:0]       acc_l;
    logic signed [ACC_W-1:0]       acc_r;
    logic [msam_pkg::MASK_W-1:0]   mask_now;
    logic                          out_free;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [OW-1:0] b);
        logic [OW:0] s;
        s = (OW + 1)'(a) + (OW + 1)'(b);
        if (32'(s) >= BUFFER_DEPTH)
        begin
            s = s - (OW + 1)'(BUFFER_DEPTH);
        end
        return AW'(s);
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [SAMPLE_BITS-1:0] b);
        logic signed [ACC_W:0] s;
        s = (ACC_W + 1)'(a) + (ACC_W + 1)'(b);
        if (s > ACC_MAX)
        begin
            s = ACC_MAX;
        end
        else if (s < ACC_MIN)
        begin
            s = ACC_MIN;
        end
        return ACC_W'(s);
    endfunction

    function automatic logic [ACC_W-1:0] magnitude(input logic signed [ACC_W-1:0] a);
        return a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] finish_quo(input logic [ACC_W-1:0] q,
                                                                 input logic neg);
        logic signed [ACC_W:0] v;
        v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (v > OUT_MAX)
        begin
            v = OUT_MAX;
        end
        else if (v < OUT_MIN)
        begin
            v = OUT_MIN;
        end
        return SAMPLE_BITS'(v);
    endfunction

    // active stream count clamped to the supported range
    always_comb
    begin
        if (32'(active_reg) < msam_pkg::MIN_STREAMS)
        begin
            n_streams = NW'(msam_pkg::MIN_STREAMS);
        end
        else if (32'(active_reg) > MAX_STREAMS)
        begin
            n_streams = NW'(MAX_STREAMS);
        end
        else
        begin
            n_streams = NW'(active_reg);
        end
    end

    assign sel       = cmd.scan_step ? scan_idx_reg : SW'(idx_reg);
    assign off_rd    = offset_reg[sel];
    assign off_ok    = 32'(off_rd) < BUFFER_DEPTH;
    assign mix_addr  = wrap_add(rp_reg, off_rd);
    assign conv_addr = wrap_add(rp_reg, k_reg);
    assign raddr     = cmd.conv_read ? conv_addr : mix_addr;

    // entries never written since reset or since they were last emitted read as zero
    assign acc_l = vld_rd_reg ? $signed(ram_rdata[2*ACC_W-1:ACC_W]) : '0;
    assign acc_r = vld_rd_reg ? $signed(ram_rdata[ACC_W-1:0]) : '0;

    assign ram_we    = cmd.mix_write && off_ok;
    assign ram_wdata = {sat_add(acc_l, sl_reg), sat_add(acc_r, sr_reg)};

    always_comb
    begin
        mask_now = '0;
        for (int s = 0; s < msam_pkg::MASK_W; s++)
        begin
            if (s < MAX_STREAMS)
            begin
                mask_now[s] = (32'(s) < 32'(n_streams)) && (offset_reg[s] <= min_reg);
            end
        end
    end

    assign out_free = !out_valid_reg || !result_stall;

    msam_ram #(
        .WIDTH (2 * ACC_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_accum (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            idx_reg  <= stream_index;
            sl_reg   <= sample_left;
            sr_reg   <= sample_right;
            last_reg <= last_of_chunk;
        end
        if (cmd.mix_read || cmd.conv_read)
        begin
            addr_reg   <= raddr;
            vld_rd_reg <= valid_reg[raddr];
        end
        if (cmd.scan_start)
        begin
            min_reg      <= '1;
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (off_rd < min_reg)
            begin
                min_reg <= off_rd;
            end
            scan_idx_reg <= scan_idx_reg + SW'(1);
        end
        if (cmd.div_start)
        begin
            num_l_reg <= magnitude(acc_l);
            num_r_reg <= magnitude(acc_r);
            neg_l_reg <= acc_l[ACC_W-1];
            neg_r_reg <= acc_r[ACC_W-1];
            rem_l_reg <= '0;
            rem_r_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            // restoring division, one quotient bit per cycle
            if ({rem_l_reg, num_l_reg[ACC_W-1]} >= {1'b0, done_reg})
            begin
                rem_l_reg <= DW'({rem_l_reg, num_l_reg[ACC_W-1]} - {1'b0, done_reg});
                num_l_reg <= {num_l_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_l_reg <= DW'({rem_l_reg, num_l_reg[ACC_W-1]});
                num_l_reg <= {num_l_reg[ACC_W-2:0], 1'b0};
            end
            if ({rem_r_reg, num_r_reg[ACC_W-1]} >= {1'b0, done_reg})
            begin
                rem_r_reg <= DW'({rem_r_reg, num_r_reg[ACC_W-1]} - {1'b0, done_reg});
                num_r_reg <= {num_r_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_r_reg <= DW'({rem_r_reg, num_r_reg[ACC_W-1]});
                num_r_reg <= {num_r_reg[ACC_W-2:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            out_l_reg    <= (done_reg == '0) ? '0 : finish_quo(num_l_reg, neg_l_reg);
            out_r_reg    <= (done_reg == '0) ? '0 : finish_quo(num_r_reg, neg_r_reg);
            out_sv_reg   <= 1'b1;
            out_last_reg <= sts.run_last;
            out_mask_reg <= mask_now;
        end
        else if (cmd.emit_none)
        begin
            out_l_reg    <= '0;
            out_r_reg    <= '0;
            out_sv_reg   <= 1'b0;
            out_last_reg <= 1'b1;
            out_mask_reg <= mask_now;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= msam_pkg::CFG_RESET;
            for (int s = 0; s < MAX_STREAMS; s++)
            begin
                offset_reg[s] <= '0;
            end
            fill_reg      <= '0;
            rp_reg        <= '0;
            done_reg      <= '0;
            valid_reg     <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (active_streams_we)
            begin
                active_reg <= active_streams;
            end
            if (cmd.mix_write)
            begin
                if (off_ok)
                begin
                    valid_reg[addr_reg] <= 1'b1;
                    offset_reg[sel]     <= off_rd + OW'(1);
                    if (off_rd + OW'(1) > fill_reg)
                    begin
                        fill_reg <= off_rd + OW'(1);
                    end
                end
                if (last_reg && (done_reg != msam_pkg::DONE_MAX))
                begin
                    done_reg <= done_reg + DW'(1);
                end
            end
            if (cmd.end_apply)
            begin
                offset_reg[sel] <= fill_reg;
            end
            if (cmd.scan_start)
            begin
                k_reg <= '0;
            end
            if (cmd.div_start)
            begin
                cnt_reg <= CW'(ACC_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cmd.emit)
            begin
                valid_reg[addr_reg] <= 1'b0;
                k_reg               <= k_reg + OW'(1);
            end
            if (cmd.conv_finish)
            begin
                for (int s = 0; s < MAX_STREAMS; s++)
                begin
                    offset_reg[s] <= (offset_reg[s] > min_reg) ? offset_reg[s] - min_reg : '0;
                end
                fill_reg <= (fill_reg > min_reg) ? fill_reg - min_reg : '0;
                rp_reg   <= wrap_add(rp_reg, min_reg);
                done_reg <= '0;
                k_reg    <= '0;
            end
            if (cmd.emit || cmd.emit_none)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.is_mix     = (func_reg == msam_pkg::FUNC_MIX);
        sts.is_end     = (func_reg == msam_pkg::FUNC_END);
        sts.is_conv    = (func_reg == msam_pkg::FUNC_CONV);
        sts.inactive   = 32'(idx_reg) >= 32'(n_streams);
        sts.scan_last  = 32'(scan_idx_reg) == 32'(n_streams) - 32'd1;
        sts.avail_zero = (min_reg == '0);
        sts.div_done   = (cnt_reg == '0);
        sts.out_free   = out_free;
        sts.run_last   = ((OW + 1)'(k_reg) + (OW + 1)'(1)) == (OW + 1)'(min_reg);
    end

    assign result_valid = out_valid_reg;
    assign mixed_left   = out_l_reg;
    assign mixed_right  = out_r_reg;
    assign sample_valid = out_sv_reg;
    assign last_of_run  = out_last_reg;
    assign need_mask    = out_mask_reg;

endmodule

`default_nettype wire

FILE: rtl/multi_stream_average_mixer.sv
// top level of the multi-stream averaging mixer
// depends on msam_pkg, msam_ctrl, msam_datapath (which holds msam_ram)
//
//  channel   handshake                        payload
//  item      item_valid / item_stall          func, stream_index, sample_left,
//                                             sample_right, last_of_chunk
//  result    result_valid / result_stall      mixed_left, mixed_right, sample_valid,
//                                             last_of_run, need_mask
//  config    active_streams_we                active_streams
//
// a mix transaction passes through accept, offset lookup with accumulator read, write back
// end and ignored transactions finish after accept and decode
// convert: minimum scan over the active stream offsets, then per result entry a read plus a
// serial divider of SAMPLE_BITS+3 steps before the result is emitted
// result register frees the datapath; a stalled result only holds the next emit
// reset clears offsets, counters and entry valid bits at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module multi_stream_average_mixer #(
    parameter int BUFFER_DEPTH = msam_pkg::DEF_BUFFER_DEPTH,
    parameter int MAX_STREAMS  = msam_pkg::DEF_MAX_STREAMS,
    parameter int SAMPLE_BITS  = msam_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic [msam_pkg::FUNC_W-1:0]   func,
    input  wire logic [msam_pkg::IDX_W-1:0]    stream_index,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_left,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_right,
    input  wire logic                          last_of_chunk,
    input  wire logic                          active_streams_we,
    input  wire logic [msam_pkg::CFG_W-1:0]    active_streams,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic signed [SAMPLE_BITS-1:0]      mixed_left,
    output logic signed [SAMPLE_BITS-1:0]      mixed_right,
    output logic                               sample_valid,
    output logic                               last_of_run,
    output logic [msam_pkg::MASK_W-1:0]        need_mask
);

    msam_pkg::cmd_t cmd;
    msam_pkg::sts_t sts;

    msam_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    msam_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .MAX_STREAMS  (MAX_STREAMS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .func              (func),
        .stream_index      (stream_index),
        .sample_left       (sample_left),
        .sample_right      (sample_right),
        .last_of_chunk     (last_of_chunk),
        .active_streams_we (active_streams_we),
        .active_streams    (active_streams),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .mixed_left        (mixed_left),
        .mixed_right       (mixed_right),
        .sample_valid      (sample_valid),
        .last_of_run       (last_of_run),
        .need_mask         (need_mask),
        .cmd               (cmd),
        .sts               (sts)
    );

endmodule

`default_nettype wire
